FILE: rtl/ilfs_pkg.sv
// Shared types, constants and keyword tables of the IRC line field splitter.
`default_nettype none

package ilfs_pkg;

   // Default configuration handed to the top level.
   localparam int LINE_BYTES_DEFAULT  = 512;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Result field widths.
   localparam int FIELD_W = 9;
   localparam logic [FIELD_W-1:0] FIELD_MAX = '1;
   localparam int KIND_W = 3;

   // Response payload: 52 field bits padded up to whole bytes.
   localparam int RSP_FIELDS_W = 52;
   localparam int RSP_W        = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_W - RSP_FIELDS_W;

   // Command token length counter saturates at its all-ones value.
   localparam int TOKEN_W    = 4;
   localparam int TOKEN_SPAN = 2 ** TOKEN_W;

   // Keyword table.
   localparam int KW_COUNT   = 4;
   localparam int KW_MAX_LEN = 9;
   localparam logic [8*KW_MAX_LEN-1:0] KW_TAGMSG_TEXT    = "TAGMSG";
   localparam logic [8*KW_MAX_LEN-1:0] KW_PRIVMSG_TEXT   = "PRIVMSG";
   localparam logic [8*KW_MAX_LEN-1:0] KW_NOTICE_TEXT    = "NOTICE";
   localparam logic [8*KW_MAX_LEN-1:0] KW_STATUSMSG_TEXT = "STATUSMSG";

   // Command kind codes.
   localparam logic [KIND_W-1:0] KIND_UNKNOWN   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TAGMSG    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PRIVMSG   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NOTICE    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STATUSMSG = 3'd4;

   // Special characters.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   // Parse phase of the line.
   typedef enum logic [2:0] {
      PH_START,
      PH_SENDER,
      PH_COMMAND,
      PH_CHANNEL,
      PH_CONTENT,
      PH_DONE
   } phase_type;

   // One classified byte as it travels from the front end to the parser.
   typedef struct packed {
      logic                                 last;
      logic                                 is_nul;
      logic                                 is_colon;
      logic                                 is_space;
      logic                                 is_crlf;
      logic [KW_COUNT-1:0][KW_MAX_LEN-1:0]  kw_hit;
   } class_type;

   // Text of keyword k, right aligned.
   function automatic logic [8*KW_MAX_LEN-1:0] kw_text(input int k);
      logic [8*KW_MAX_LEN-1:0] txt;
      case (k)
         0:       txt = KW_TAGMSG_TEXT;
         1:       txt = KW_PRIVMSG_TEXT;
         2:       txt = KW_NOTICE_TEXT;
         3:       txt = KW_STATUSMSG_TEXT;
         default: txt = '0;
      endcase
      return txt;
   endfunction

   // Length of keyword k in characters.
   function automatic int kw_len(input int k);
      int len;
      case (k)
         0:       len = 6;
         1:       len = 7;
         2:       len = 6;
         3:       len = 9;
         default: len = 0;
      endcase
      return len;
   endfunction

   // Command kind reported for keyword k.
   function automatic logic [KIND_W-1:0] kw_kind(input int k);
      logic [KIND_W-1:0] kind;
      case (k)
         0:       kind = KIND_TAGMSG;
         1:       kind = KIND_PRIVMSG;
         2:       kind = KIND_NOTICE;
         3:       kind = KIND_STATUSMSG;
         default: kind = KIND_UNKNOWN;
      endcase
      return kind;
   endfunction

   // Character i of keyword k; zero past the end of the keyword.
   function automatic logic [7:0] kw_char(input int k, input int i);
      logic [8*KW_MAX_LEN-1:0] txt;
      int                      len;
      logic [7:0]              ch;
      txt = kw_text(k);
      len = kw_len(k);
      ch  = 8'h00;
      if (i < len) begin
         ch = txt[8*(len-1-i) +: 8];
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/ilfs_front.sv
// Front end: classifies each incoming line byte against separators and keywords.
`default_nettype none

module ilfs_front (
   input  wire logic [7:0]          byte_data,
   input  wire logic                byte_last,
   output ilfs_pkg::class_type      byte_class
);
   import ilfs_pkg::*;

   // Separator and terminator detection, plus one compare per keyword character.
   always_comb begin
      byte_class.last     = byte_last;
      byte_class.is_nul   = (byte_data == CHAR_NUL);
      byte_class.is_colon = (byte_data == CHAR_COLON);
      byte_class.is_space = (byte_data == CHAR_SPACE);
      byte_class.is_crlf  = (byte_data == CHAR_CR) || (byte_data == CHAR_LF);
      for (int k = 0; k < KW_COUNT; k++) begin
         for (int i = 0; i < KW_MAX_LEN; i++) begin
            byte_class.kw_hit[k][i] = (i < kw_len(k)) && (byte_data == kw_char(k, i));
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ilfs_queue.sv
// Short queue of classified bytes between the front end and the parser.
`default_nettype none

module ilfs_queue #(
   parameter int DEPTH = ilfs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire ilfs_pkg::class_type push_data,
   output logic                     full,
   input  wire logic                pop,
   output logic                     head_valid,
   output ilfs_pkg::class_type      head_data
);
   import ilfs_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   class_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates; pointers wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ilfs_back.sv
// Back end: per-byte parse engine and the registered response stage.
`default_nettype none

module ilfs_back #(
   parameter int LINE_BYTES = ilfs_pkg::LINE_BYTES_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     head_valid,
   input  wire ilfs_pkg::class_type      head,
   output logic                          pop,
   input  wire logic                     rsp_tready,
   output logic                          rsp_tvalid,
   output logic [ilfs_pkg::RSP_W-1:0]    rsp_tdata
);
   import ilfs_pkg::*;

   localparam int PW     = $clog2(LINE_BYTES + 1);
   localparam int WIDE_W = (PW > FIELD_W) ? PW : FIELD_W;

   // Parse state.
   phase_type             phase_ff, phase_in;
   logic [PW-1:0]         position_ff, position_in, position_upd;
   logic [KW_COUNT-1:0]   kw_mask_ff, kw_mask_in, kw_mask_upd, kw_mask_next;
   logic [TOKEN_W-1:0]    token_len_ff, token_len_in, token_len_upd;
   logic [KIND_W-1:0]     found_kind_ff, found_kind_in, found_kind_upd, end_kind;
   logic [FIELD_W-1:0]    sender_span_ff, sender_span_in, sender_span_upd;
   logic [FIELD_W-1:0]    chan_start_ff, chan_start_in, chan_start_upd;
   logic [FIELD_W-1:0]    chan_len_ff, chan_len_in, chan_len_upd;
   logic [FIELD_W-1:0]    body_start_ff, body_start_in, body_start_upd;
   logic [FIELD_W-1:0]    body_len_ff, body_len_in, body_len_upd;
   logic                  sender_flag_ff, sender_flag_in, sender_flag_upd;
   logic                  chan_flag_ff, chan_flag_in, chan_flag_upd;
   logic                  token_start_ff, token_start_in, token_start_upd;
   logic                  cut_ff, cut_in, cut_upd;
   logic                  too_long_ff, too_long_in, too_long_upd;

   // Response stage.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   // Byte handling conditions.
   logic                  out_free;
   logic                  active;
   logic                  finish;
   logic                  pos_full;
   logic                  step;
   logic [PW-1:0]         pos_p1;
   logic [WIDE_W-1:0]     pos_p1_wide;
   logic                  p1_ovf;
   logic [FIELD_W-1:0]    p1_sat;
   logic                  present;
   logic                  snd;
   logic                  chn;

   // A final byte waits until the response register can take the result.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign active   = head_valid && (!head.last || out_free);
   assign finish   = active && head.last;
   assign pop      = active;

   assign pos_full    = (position_ff >= PW'(LINE_BYTES));
   assign step        = active && (phase_ff != PH_DONE) && !pos_full && !head.is_nul;
   assign pos_p1      = position_ff + PW'(1);
   assign pos_p1_wide = WIDE_W'(pos_p1);
   assign p1_ovf      = (pos_p1_wide > WIDE_W'(FIELD_MAX));
   assign p1_sat      = p1_ovf ? FIELD_MAX : FIELD_W'(pos_p1_wide);

   // Keyword matching: a keyword stays live while its next character matches.
   always_comb begin
      logic [TOKEN_SPAN-1:0] hits;
      end_kind = KIND_UNKNOWN;
      for (int k = 0; k < KW_COUNT; k++) begin
         hits            = {{(TOKEN_SPAN - KW_MAX_LEN){1'b0}}, head.kw_hit[k]};
         kw_mask_next[k] = kw_mask_ff[k] && hits[token_len_ff];
         if (kw_mask_ff[k] && (token_len_ff == TOKEN_W'(kw_len(k)))) begin
            end_kind = kw_kind(k);
         end
      end
   end

   // Next parse phase.
   always_comb begin
      phase_in = phase_ff;
      if (active && (phase_ff != PH_DONE) && !pos_full) begin
         if (head.is_nul) begin
            phase_in = PH_DONE;
         end else begin
            case (phase_ff)
               PH_START: begin
                  if (head.is_colon) begin
                     phase_in = PH_SENDER;
                  end else if (head.is_space) begin
                     phase_in = PH_CHANNEL;
                  end else begin
                     phase_in = PH_COMMAND;
                  end
               end
               PH_SENDER:  if (head.is_space) phase_in = PH_COMMAND;
               PH_COMMAND: if (head.is_space) phase_in = PH_CHANNEL;
               PH_CHANNEL: if (head.is_space) phase_in = PH_CONTENT;
               default:    phase_in = phase_ff;
            endcase
         end
      end
      if (finish) begin
         phase_in = PH_START;
      end
   end

   // Field tracking for one byte: spans, keyword state and tentative content.
   always_comb begin
      phase_type ph;
      logic      new_tok;
      logic      do_body;
      logic      skip;
      position_upd    = position_ff;
      kw_mask_upd     = kw_mask_ff;
      token_len_upd   = token_len_ff;
      found_kind_upd  = found_kind_ff;
      sender_span_upd = sender_span_ff;
      chan_start_upd  = chan_start_ff;
      chan_len_upd    = chan_len_ff;
      body_start_upd  = body_start_ff;
      body_len_upd    = body_len_ff;
      sender_flag_upd = sender_flag_ff;
      chan_flag_upd   = chan_flag_ff;
      token_start_upd = token_start_ff;
      cut_upd         = cut_ff;
      too_long_upd    = too_long_ff;
      ph      = phase_ff;
      new_tok = 1'b0;
      do_body = 1'b0;
      skip    = 1'b0;

      // Bytes beyond the line bound are dropped and flagged.
      if (active && (phase_ff != PH_DONE) && pos_full) begin
         too_long_upd = 1'b1;
      end

      if (step) begin
         position_upd = pos_p1;
         // A line without a sender prefix opens its command token at offset zero.
         if ((ph == PH_START) && !head.is_colon) begin
            ph              = PH_COMMAND;
            token_start_upd = 1'b1;
         end
         case (ph)
            PH_START: begin
               body_start_upd  = FIELD_W'(1);
               body_len_upd    = '0;
               token_start_upd = 1'b1;
               cut_upd         = 1'b0;
            end
            PH_SENDER: begin
               if (head.is_space) begin
                  sender_flag_upd = 1'b1;
                  kw_mask_upd     = '1;
                  token_len_upd   = '0;
                  new_tok         = 1'b1;
               end else begin
                  if (sender_span_ff == FIELD_MAX) begin
                     too_long_upd = 1'b1;
                  end else begin
                     sender_span_upd = sender_span_ff + FIELD_W'(1);
                  end
                  do_body = 1'b1;
               end
            end
            PH_COMMAND: begin
               if (head.is_space) begin
                  found_kind_upd = end_kind;
                  chan_start_upd = p1_sat;
                  chan_len_upd   = '0;
                  if (p1_ovf) begin
                     too_long_upd = 1'b1;
                  end
                  new_tok = 1'b1;
               end else begin
                  kw_mask_upd = kw_mask_next;
                  if (token_len_ff != '1) begin
                     token_len_upd = token_len_ff + TOKEN_W'(1);
                  end
                  do_body = 1'b1;
               end
            end
            PH_CHANNEL: begin
               if (head.is_space) begin
                  chan_flag_upd = 1'b1;
                  new_tok       = 1'b1;
               end else begin
                  if (chan_len_ff == FIELD_MAX) begin
                     too_long_upd = 1'b1;
                  end else begin
                     chan_len_upd = chan_len_ff + FIELD_W'(1);
                  end
                  do_body = 1'b1;
               end
            end
            default: begin
               do_body = 1'b1;
            end
         endcase

         // A new token restarts the tentative content after this byte.
         if (new_tok) begin
            body_start_upd  = p1_sat;
            body_len_upd    = '0;
            token_start_upd = 1'b1;
            cut_upd         = 1'b0;
            if (p1_ovf) begin
               too_long_upd = 1'b1;
            end
         end

         // Content: one leading colon is skipped, CR or LF cuts the length.
         if (do_body) begin
            if (token_start_upd) begin
               token_start_upd = 1'b0;
               if (head.is_colon) begin
                  body_start_upd = p1_sat;
                  if (p1_ovf) begin
                     too_long_upd = 1'b1;
                  end
                  skip = 1'b1;
               end
            end
            if (!skip && !cut_upd) begin
               if (head.is_crlf) begin
                  cut_upd = 1'b1;
               end else if (body_len_upd == FIELD_MAX) begin
                  too_long_upd = 1'b1;
               end else begin
                  body_len_upd = body_len_upd + FIELD_W'(1);
               end
            end
         end
      end
   end

   // The state returns to its line start values once a line is reported.
   always_comb begin
      if (finish) begin
         position_in    = '0;
         kw_mask_in     = '1;
         token_len_in   = '0;
         found_kind_in  = KIND_UNKNOWN;
         sender_span_in = '0;
         chan_start_in  = '0;
         chan_len_in    = '0;
         body_start_in  = '0;
         body_len_in    = '0;
         sender_flag_in = 1'b0;
         chan_flag_in   = 1'b0;
         token_start_in = 1'b0;
         cut_in         = 1'b0;
         too_long_in    = 1'b0;
      end else begin
         position_in    = position_upd;
         kw_mask_in     = kw_mask_upd;
         token_len_in   = token_len_upd;
         found_kind_in  = found_kind_upd;
         sender_span_in = sender_span_upd;
         chan_start_in  = chan_start_upd;
         chan_len_in    = chan_len_upd;
         body_start_in  = body_start_upd;
         body_len_in    = body_len_upd;
         sender_flag_in = sender_flag_upd;
         chan_flag_in   = chan_flag_upd;
         token_start_in = token_start_upd;
         cut_in         = cut_upd;
         too_long_in    = too_long_upd;
      end
   end

   // Response assembly; an empty line reports all zeros.
   assign present = (position_upd != '0);
   assign snd     = present && sender_flag_upd;
   assign chn     = present && chan_flag_upd;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (present) begin
            rsp_data_in = {
               RSP_PAD_W'(0),
               too_long_upd,
               body_len_upd,
               body_start_upd,
               chn ? chan_len_upd : {FIELD_W{1'b0}},
               chn ? chan_start_upd : {FIELD_W{1'b0}},
               chn,
               found_kind_upd,
               snd ? sender_span_upd : {FIELD_W{1'b0}},
               snd,
               1'b1
            };
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_START;
         position_ff    <= '0;
         kw_mask_ff     <= '1;
         token_len_ff   <= '0;
         found_kind_ff  <= KIND_UNKNOWN;
         sender_span_ff <= '0;
         chan_start_ff  <= '0;
         chan_len_ff    <= '0;
         body_start_ff  <= '0;
         body_len_ff    <= '0;
         sender_flag_ff <= 1'b0;
         chan_flag_ff   <= 1'b0;
         token_start_ff <= 1'b0;
         cut_ff         <= 1'b0;
         too_long_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         position_ff    <= position_in;
         kw_mask_ff     <= kw_mask_in;
         token_len_ff   <= token_len_in;
         found_kind_ff  <= found_kind_in;
         sender_span_ff <= sender_span_in;
         chan_start_ff  <= chan_start_in;
         chan_len_ff    <= chan_len_in;
         body_start_ff  <= body_start_in;
         body_len_ff    <= body_len_in;
         sender_flag_ff <= sender_flag_in;
         chan_flag_ff   <= chan_flag_in;
         token_start_ff <= token_start_in;
         cut_ff         <= cut_in;
         too_long_ff    <= too_long_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

FILE: rtl/irc_line_field_splitter.sv
// Top level of the IRC line field splitter: front end, byte queue and parser.
//
// Usage: a received IRC line enters on the req_ stream one byte per transaction,
// with req_tlast on its final byte. For every line one transaction leaves on the
// rsp_ stream, describing the sender, command kind, channel and content as byte
// offsets and lengths; an empty line gives a transaction with present clear.
// A NUL byte ends the string early; the following bytes up to req_tlast are
// consumed without effect. Bytes past LINE_BYTES are dropped and set too_long.
// Throughput: one byte per clock cycle while no stall holds the parser.
// Path: with the queue empty, the final byte's transaction writes the byte
// queue; from there the byte moves through the parser into the response
// register, whose output drives rsp_tvalid and rsp_tdata.
// Stalls: while rsp_tready is low, the parser keeps working on bytes of the
// next line and halts only at its final byte; the queue of QUEUE_DEPTH bytes
// then fills and req_tready falls. A held response stays stable.
// Reset: synchronous and active high; it empties the queue, drops any pending
// response and returns the parser to the start of a line.
`default_nettype none

module irc_line_field_splitter #(
   parameter int LINE_BYTES  = ilfs_pkg::LINE_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH = ilfs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // req_tdata: [7:0] line_byte
   input  wire logic [7:0]               req_tdata,
   input  wire logic                     req_tlast,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // rsp_tdata: [0] present, [1] has_sender, [10:2] sender_length,
   // [13:11] command_kind, [14] has_channel, [23:15] channel_start,
   // [32:24] channel_length, [41:33] content_start, [50:42] content_length,
   // [51] too_long, [55:52] zero
   output logic [ilfs_pkg::RSP_W-1:0]    rsp_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready
);
   import ilfs_pkg::*;

   class_type  byte_class;
   class_type  head;
   logic       queue_full;
   logic       head_valid;
   logic       pop;
   logic       push;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   ilfs_front u_front (
      .byte_data  (req_tdata),
      .byte_last  (req_tlast),
      .byte_class (byte_class)
   );

   ilfs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (byte_class),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head)
   );

   ilfs_back #(
      .LINE_BYTES (LINE_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: rtl/ilfs_checker.sv
// Port-level assertions for the IRC line field splitter and their bind.
`default_nettype none

module ilfs_checker (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [7:0]               req_tdata,
   input  wire logic                     req_tlast,
   input  wire logic                     req_tvalid,
   input  wire logic                     req_tready,
   input  wire logic [ilfs_pkg::RSP_W-1:0] rsp_tdata,
   input  wire logic                     rsp_tvalid,
   input  wire logic                     rsp_tready
);
   import ilfs_pkg::*;

   // A stalled response transaction holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Reset leaves no response pending.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // An empty line reports every field as zero.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[RSP_W-1:1] == '0)
      else $error("empty line with nonzero fields");

   // Without a sender prefix the sender length is zero.
   a_sender_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[10:2] == '0)
      else $error("sender length without sender");

   // Without a channel token its span is zero.
   a_channel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[14] |-> rsp_tdata[32:15] == '0)
      else $error("channel span without channel");

endmodule

bind irc_line_field_splitter ilfs_checker u_ilfs_checker (.*);

`default_nettype wire

FILE: test/irc_line_field_splitter_tb.sv
// Self-checking testbench of the IRC line field splitter: random lines in, parsed offsets checked.
module irc_line_field_splitter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ilfs_pkg::*;

   localparam int LINE_LIMIT   = LINE_BYTES_DEFAULT;
   localparam int SPAN_MAX     = 511;
   localparam int TOKEN_MAX    = TOKEN_SPAN - 1;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int ITEM_TARGET  = 900;
   localparam int DRAIN_CYCLES = 8;

   // One response transaction, laid out as on rsp_tdata (last field at the top).
   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic                 too_long;
      logic [FIELD_W-1:0]   content_length;
      logic [FIELD_W-1:0]   content_start;
      logic [FIELD_W-1:0]   channel_length;
      logic [FIELD_W-1:0]   channel_start;
      logic                 has_channel;
      logic [KIND_W-1:0]    command_kind;
      logic [FIELD_W-1:0]   sender_length;
      logic                 has_sender;
      logic                 present;
   } line_fields_type;

   typedef logic [7:0] line_type[$];

   // Tracks the parse of the current line and holds the descriptions of finished lines.
   class line_scoreboard;
      line_fields_type   parsed_q[$];
      int                failures;
      string             keywords[4];
      logic [KIND_W-1:0] keyword_kinds[4];
      phase_type         ph;
      int                offset;
      int                cmd_len;
      int                sender_len;
      int                chan_at;
      int                chan_len;
      int                body_at;
      int                body_len;
      logic [KIND_W-1:0] kind;
      logic [3:0]        kw_live;
      bit                sender_seen;
      bit                chan_seen;
      bit                fresh;
      bit                cut;
      bit                overflow;

      function new();
         keywords      = '{"TAGMSG", "PRIVMSG", "NOTICE", "STATUSMSG"};
         keyword_kinds = '{KIND_TAGMSG, KIND_PRIVMSG, KIND_NOTICE, KIND_STATUSMSG};
         failures      = 0;
         restart();
      endfunction

      function void restart();
         ph          = PH_START;
         offset      = 0;
         cmd_len     = 0;
         sender_len  = 0;
         chan_at     = 0;
         chan_len    = 0;
         body_at     = 0;
         body_len    = 0;
         kind        = KIND_UNKNOWN;
         kw_live     = 4'hF;
         sender_seen = 1'b0;
         chan_seen   = 1'b0;
         fresh       = 1'b0;
         cut         = 1'b0;
         overflow    = 1'b0;
      endfunction

      function int pending();
         return parsed_q.size();
      endfunction

      // Offsets and lengths hold at the field maximum and flag the line as too long.
      function int clip(int v);
         if (v > SPAN_MAX) begin
            overflow = 1'b1;
            return SPAN_MAX;
         end
         return v;
      endfunction

      // A token, and with it a tentative content span, starts here.
      function void open_token(int at);
         body_at  = clip(at);
         body_len = 0;
         fresh    = 1'b1;
         cut      = 1'b0;
      endfunction

      // Content span: one leading colon is skipped, and CR or LF cuts it.
      function void content_byte(logic [7:0] b, int at);
         if (fresh) begin
            fresh = 1'b0;
            if (b == CHAR_COLON) begin
               body_at = clip(at + 1);
               return;
            end
         end
         if (cut) return;
         if (b == CHAR_CR || b == CHAR_LF) begin
            cut = 1'b1;
         end else begin
            body_len = clip(body_len + 1);
         end
      endfunction

      function void command_byte(logic [7:0] b, int at);
         for (int k = 0; k < 4; k++) begin
            if (kw_live[k] && (cmd_len >= keywords[k].len() || keywords[k][cmd_len] != b)) begin
               kw_live[k] = 1'b0;
            end
         end
         if (cmd_len < TOKEN_MAX) cmd_len++;
         content_byte(b, at);
      endfunction

      // A space closes the command token; the channel token starts after it.
      function void end_command(int at);
         kind = KIND_UNKNOWN;
         for (int k = 0; k < 4; k++) begin
            if (kw_live[k] && cmd_len == keywords[k].len()) kind = keyword_kinds[k];
         end
         ph       = PH_CHANNEL;
         chan_at  = clip(at + 1);
         chan_len = 0;
         open_token(at + 1);
      endfunction

      function void take(logic [7:0] b);
         int at;
         at = offset;
         if (ph == PH_DONE) return;
         if (at >= LINE_LIMIT) begin
            overflow = 1'b1;
            return;
         end
         if (b == CHAR_NUL) begin
            ph = PH_DONE;
            return;
         end
         case (ph)
            PH_START: begin
               if (b == CHAR_COLON) begin
                  ph = PH_SENDER;
                  open_token(1);
               end else begin
                  ph = PH_COMMAND;
                  open_token(0);
                  if (b == CHAR_SPACE) end_command(at);
                  else command_byte(b, at);
               end
            end
            PH_SENDER: begin
               if (b == CHAR_SPACE) begin
                  sender_seen = 1'b1;
                  ph          = PH_COMMAND;
                  kw_live     = 4'hF;
                  cmd_len     = 0;
                  open_token(at + 1);
               end else begin
                  sender_len = clip(sender_len + 1);
                  content_byte(b, at);
               end
            end
            PH_COMMAND: begin
               if (b == CHAR_SPACE) end_command(at);
               else command_byte(b, at);
            end
            PH_CHANNEL: begin
               if (b == CHAR_SPACE) begin
                  chan_seen = 1'b1;
                  ph        = PH_CONTENT;
                  open_token(at + 1);
               end else begin
                  chan_len = clip(chan_len + 1);
                  content_byte(b, at);
               end
            end
            default: content_byte(b, at);
         endcase
         offset = at + 1;
      endfunction

      // Notes one accepted request transaction; the final byte queues the line's description.
      function void note_byte(logic [7:0] b, logic last);
         line_fields_type want;
         take(b);
         if (!last) return;
         want = '0;
         if (offset != 0) begin
            want.present      = 1'b1;
            want.command_kind = kind;
            if (sender_seen) begin
               want.has_sender    = 1'b1;
               want.sender_length = FIELD_W'(sender_len);
            end
            if (chan_seen) begin
               want.has_channel    = 1'b1;
               want.channel_start  = FIELD_W'(chan_at);
               want.channel_length = FIELD_W'(chan_len);
            end
            want.content_start  = FIELD_W'(body_at);
            want.content_length = FIELD_W'(body_len);
            want.too_long       = overflow;
         end
         parsed_q.push_back(want);
         restart();
      endfunction

      function void compare(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      // Checks one response transaction against the oldest finished line.
      function void check_result(logic [RSP_W-1:0] data);
         line_fields_type got;
         line_fields_type want;
         got = data;
         if (parsed_q.size() == 0) begin
            $error("response transaction with no line waiting: %h", data);
            failures++;
            return;
         end
         want = parsed_q.pop_front();
         compare("present", FIELD_W'(want.present), FIELD_W'(got.present));
         compare("has_sender", FIELD_W'(want.has_sender), FIELD_W'(got.has_sender));
         compare("sender_length", want.sender_length, got.sender_length);
         compare("command_kind", FIELD_W'(want.command_kind), FIELD_W'(got.command_kind));
         compare("has_channel", FIELD_W'(want.has_channel), FIELD_W'(got.has_channel));
         compare("channel_start", want.channel_start, got.channel_start);
         compare("channel_length", want.channel_length, got.channel_length);
         compare("content_start", want.content_start, got.content_start);
         compare("content_length", want.content_length, got.content_length);
         compare("too_long", FIELD_W'(want.too_long), FIELD_W'(got.too_long));
         compare("pad", FIELD_W'(want.pad), FIELD_W'(got.pad));
      endfunction
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic [7:0]         req_tdata  = '0;
   logic               req_tlast  = 1'b0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;

   line_scoreboard     board;
   int                 cycles     = 0;
   int                 sent_items = 0;
   int                 line_run   = 0;
   bit                 line_eager = 1'b0;

   irc_line_field_splitter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $error("run timed out after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Both channels are observed at the clock edge that completes a transaction.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      end
   end

   // Response side: a random stall before each transaction, with runs of no stall.
   initial begin : rsp_side
      int stall;
      int run_left;
      bit quick;
      run_left = 0;
      quick    = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (run_left == 0) begin
            run_left = $urandom_range(1, 8);
            quick    = ($urandom_range(0, 2) == 0);
         end
         run_left--;
         stall = quick ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Offers one byte after an optional gap and returns at the edge that takes it.
   task automatic put_byte(input logic [7:0] b, input logic last, input bit eager);
      int gap;
      gap = eager ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= b;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Sends a whole line; lines come in runs that either idle between bytes or do not.
   task automatic send_line(input line_type text);
      if (line_run == 0) begin
         line_run   = $urandom_range(1, 6);
         line_eager = ($urandom_range(0, 2) == 0);
      end
      line_run--;
      foreach (text[i]) begin
         sent_items++;
         put_byte(text[i], i == text.size() - 1, line_eager);
      end
   endtask

   // Holds the request side idle until every finished line has been answered.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   function automatic line_type from_text(string s);
      line_type q;
      foreach (s[i]) q.push_back(s[i]);
      return q;
   endfunction

   function automatic logic [7:0] token_char();
      return 8'($urandom_range(8'h21, 8'h7E));
   endfunction

   // Content bytes: mostly printable, with spaces, colons and line breaks mixed in.
   function automatic logic [7:0] text_char();
      case ($urandom_range(0, 19))
         0:       return CHAR_CR;
         1:       return CHAR_LF;
         2:       return CHAR_SPACE;
         3:       return CHAR_COLON;
         default: return token_char();
      endcase
   endfunction

   // Command token: a keyword, a near miss of one, or random capitals.
   function automatic void add_command(ref line_type q);
      string word;
      int    n;
      word = board.keywords[$urandom_range(0, 3)];
      case ($urandom_range(0, 6))
         2: word = word.substr(0, word.len() - 2);
         3: word = {word, "S"};
         4: word[$urandom_range(0, word.len() - 1)] = "X";
         5: word = word.tolower();
         6: begin
            word = "";
            n = $urandom_range(1, 20);
            repeat (n) q.push_back(8'($urandom_range(8'h41, 8'h5A)));
         end
         default: ;
      endcase
      foreach (word[i]) q.push_back(word[i]);
   endfunction

   // A well-formed line with random content: [:sender ]command #channel [:]content[CRLF].
   function automatic line_type make_message(int body_min, int body_max);
      line_type q;
      int       n;
      if ($urandom_range(0, 2) != 0) begin
         q.push_back(CHAR_COLON);
         n = $urandom_range(0, 12);
         repeat (n) q.push_back(token_char());
         q.push_back(CHAR_SPACE);
      end
      add_command(q);
      q.push_back(CHAR_SPACE);
      q.push_back("#");
      n = $urandom_range(0, 10);
      repeat (n) q.push_back(token_char());
      q.push_back(CHAR_SPACE);
      if ($urandom_range(0, 1) != 0) q.push_back(CHAR_COLON);
      n = $urandom_range(body_min, body_max);
      repeat (n) q.push_back(text_char());
      if ($urandom_range(0, 2) == 0) begin
         q.push_back(CHAR_CR);
         q.push_back(CHAR_LF);
      end
      return q;
   endfunction

   // Damages a line: cut short, a NUL, an extra space or one random byte.
   function automatic line_type break_line(line_type q);
      int idx;
      idx = $urandom_range(0, q.size() - 1);
      case ($urandom_range(0, 3))
         0:       q = q[0:idx];
         1:       q[idx] = CHAR_NUL;
         2:       q.insert(idx, CHAR_SPACE);
         default: q[idx] = 8'($urandom_range(1, 255));
      endcase
      return q;
   endfunction

   function automatic line_type noise_line();
      line_type q;
      int       n;
      n = $urandom_range(1, 24);
      repeat (n) begin
         case ($urandom_range(0, 9))
            0:       q.push_back(CHAR_COLON);
            1:       q.push_back(CHAR_SPACE);
            2:       q.push_back(($urandom_range(0, 1) != 0) ? CHAR_CR : CHAR_LF);
            3:       q.push_back(($urandom_range(0, 3) == 0) ? CHAR_NUL : token_char());
            default: q.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      return q;
   endfunction

   // Main sequence: reset, directed lines, random lines, drain and verdict.
   initial begin
      line_type q;
      int       pick;
      int       random_lines;
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lines: each keyword, missing separators, NUL and empty lines, byte extremes.
      send_line(from_text(":nick!u@host PRIVMSG #chan :hello there\r\n"));
      send_line(from_text(":srv NOTICE #c :note"));
      send_line(from_text("TAGMSG #x :t"));
      send_line(from_text(":a STATUSMSG #ops hi\n"));
      q = {CHAR_NUL};
      send_line(q);
      q = {CHAR_NUL, 8'h41, CHAR_SPACE, 8'h42};
      send_line(q);
      send_line(from_text(":nospace"));
      send_line(from_text("::x"));
      send_line(from_text(":s PRIVMSGX #c :m"));
      send_line(from_text(":s PRIVMS"));
      send_line(from_text(":s NOTICE #chan"));
      send_line(from_text("PING :server"));
      send_line(from_text(" lead"));
      send_line(from_text(":s ABCDEFGHIJKLMNOPQRST #c :x"));
      send_line(from_text(":s PRIVMSG #c :a\rb\nc"));
      send_line(from_text(": TAGMSG  :"));
      q = {8'hFF, 8'h80, 8'h7F, 8'h01};
      send_line(q);
      send_line(from_text("x"));
      q = from_text("PRIVMSG #c hi");
      q.push_back(CHAR_NUL);
      q = {q, from_text("more")};
      send_line(q);
      // A line past the bound: the channel ends on the last byte, so the content
      // offset saturates and the tail is dropped.
      q = from_text("PRIVMSG #");
      repeat (502) q.push_back("c");
      q = {q, from_text(" tail")};
      send_line(q);
      wait_drained();

      // Random lines: mostly well-formed, some damaged, some noise.
      random_lines = 0;
      while (sent_items < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) q = make_message(0, 30);
         else if (pick < 85) q = break_line(make_message(0, 20));
         else q = noise_line();
         send_line(q);
         random_lines++;
         if (random_lines % 3 == 0) wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
